// ===== rtl/core/acc_pkg.sv =====
// shared types and constants of the alarm clock core
`default_nettype none

package acc_pkg;

	localparam int DIGIT_COUNT = 6;
	localparam int DIGIT_W     = 4;
	localparam int TPS_W       = 16;
	localparam int CURSOR_W    = 3;

	localparam logic [TPS_W-1:0]    TPS_RESET   = 16'd2000;
	localparam logic [CURSOR_W-1:0] CURSOR_FULL = CURSOR_W'(DIGIT_COUNT);

	// request codes
	localparam logic [2:0] REQ_TICK      = 3'd0;
	localparam logic [2:0] REQ_SET_MODE  = 3'd1;
	localparam logic [2:0] REQ_DIGIT     = 3'd2;
	localparam logic [2:0] REQ_BACKSPACE = 3'd3;
	localparam logic [2:0] REQ_CONFIRM   = 3'd4;
	localparam logic [2:0] REQ_CANCEL    = 3'd5;

	// digit values
	localparam logic [DIGIT_W-1:0] BLANK_DIGIT    = 4'd10;
	localparam logic [DIGIT_W-1:0] LAST_DIGIT     = 4'd9;
	localparam logic [DIGIT_W-1:0] LAST_TENS      = 4'd5;
	localparam logic [DIGIT_W-1:0] HOUR_TENS_WRAP = 4'd2;
	localparam logic [DIGIT_W-1:0] HOUR_ONES_WRAP = 4'd4;

	// digit positions, most significant first
	localparam int POS_HOUR_TENS   = 0;
	localparam int POS_HOUR_ONES   = 1;
	localparam int POS_MINUTE_TENS = 2;
	localparam int POS_MINUTE_ONES = 3;
	localparam int POS_SECOND_TENS = 4;
	localparam int POS_SECOND_ONES = 5;

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef digit_t [DIGIT_COUNT-1:0] digits_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic [3:0] key_digit;
	} req_t;

	typedef struct packed {
		logic [1:0] hour_tens;
		logic [3:0] hour_ones;
		logic [2:0] minute_tens;
		logic [3:0] minute_ones;
		logic [2:0] second_tens;
		logic [3:0] second_ones;
		logic       alarm_armed;
		logic       alarm_ringing;
		logic       buzzer_level;
		logic [2:0] entry_cursor;
		logic       setting_mode;
	} rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/acc_timekeeper.sv =====
// tick prescaler and hh:mm:ss bcd time counter
`default_nettype none

module acc_timekeeper (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     tick,
	input  wire logic [acc_pkg::TPS_W-1:0] ticks_per_second,
	output acc_pkg::digits_t               time_next
);
	import acc_pkg::*;

	logic [TPS_W-1:0] prescaler_q;
	logic [TPS_W-1:0] prescaler_inc;
	logic [TPS_W-1:0] prescaler_d;
	logic             second;
	digits_t          time_q;

	always_comb begin
		prescaler_inc = prescaler_q + TPS_W'(1);
		second        = (prescaler_inc >= ticks_per_second);
		prescaler_d   = second ? '0 : prescaler_inc;
	end

	// ripple the carry through the digits
	always_comb begin
		time_next = time_q;
		if (tick && second) begin
			if (time_q[POS_SECOND_ONES] != LAST_DIGIT) begin
				time_next[POS_SECOND_ONES] = time_q[POS_SECOND_ONES] + 4'd1;
			end else begin
				time_next[POS_SECOND_ONES] = '0;
				if (time_q[POS_SECOND_TENS] != LAST_TENS) begin
					time_next[POS_SECOND_TENS] = time_q[POS_SECOND_TENS] + 4'd1;
				end else begin
					time_next[POS_SECOND_TENS] = '0;
					if (time_q[POS_MINUTE_ONES] != LAST_DIGIT) begin
						time_next[POS_MINUTE_ONES] = time_q[POS_MINUTE_ONES] + 4'd1;
					end else begin
						time_next[POS_MINUTE_ONES] = '0;
						if (time_q[POS_MINUTE_TENS] != LAST_TENS) begin
							time_next[POS_MINUTE_TENS] = time_q[POS_MINUTE_TENS] + 4'd1;
						end else begin
							time_next[POS_MINUTE_TENS] = '0;
							if (time_q[POS_HOUR_ONES] != LAST_DIGIT) begin
								time_next[POS_HOUR_ONES] = time_q[POS_HOUR_ONES] + 4'd1;
							end else begin
								time_next[POS_HOUR_ONES] = '0;
								time_next[POS_HOUR_TENS] = time_q[POS_HOUR_TENS] + 4'd1;
							end
							// midnight
							if (time_next[POS_HOUR_TENS] >= HOUR_TENS_WRAP &&
									time_next[POS_HOUR_ONES] >= HOUR_ONES_WRAP) begin
								time_next[POS_HOUR_TENS] = '0;
								time_next[POS_HOUR_ONES] = '0;
							end
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescaler_q <= '0;
			time_q      <= '0;
		end else begin
			if (tick) begin
				prescaler_q <= prescaler_d;
			end
			time_q <= time_next;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/alarm_clock_core.sv =====
// top level of the alarm clock core: request decode, alarm entry and result register
`default_nettype none

// Time-of-day clock with a keypad-entered alarm. Each accepted request gives
// exactly one result showing the clock state after that request. Tick requests
// drive a prescaler; every ticks_per_second ticks (0 counts as 1) the HH:MM:SS
// counter steps one second, wrapping at 24 hours. Key requests enter setting
// mode, type alarm digits (0..9, ignored outside setting mode or when six are
// in), backspace, confirm, and cancel a ringing alarm. Once six digits are in
// and a confirm has been seen, the alarm is armed; while armed, a full match of
// time and alarm digits starts ringing and each tick then toggles the buzzer.
// Rate: one request per clock while res_ready keeps the result register free. A
// request is held in an input stage register and its result is written to the
// result register when that register is free or being emptied; the state update
// is a single pass through the decode and bcd carry logic. The result register
// lets the next request be taken while a finished result still waits.
// ticks_per_second is written through cfg_we/cfg_data; the user must write it
// only while no request is in flight, which the block does not enforce.
module alarm_clock_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// request channel
	input  wire logic                      req_valid,
	output logic                           req_ready,
	input  wire acc_pkg::req_t              req,
	// result channel
	output logic                           res_valid,
	input  wire logic                      res_ready,
	output acc_pkg::rsp_t                   res,
	// configuration
	input  wire logic                      cfg_we,
	input  wire logic [acc_pkg::TPS_W-1:0] cfg_data
);
	import acc_pkg::*;

	// configuration register
	logic [TPS_W-1:0] tps_q;

	// input stage
	logic req_valid_s1;
	req_t req_s1;

	// result register
	logic res_valid_q;
	rsp_t res_q;

	// alarm and entry state
	digits_t             alarm_q, alarm_d;
	logic [CURSOR_W-1:0] cursor_q, cursor_d;
	logic                mode_q, mode_d;
	logic                confirm_q, confirm_d;
	logic                armed_q, armed_d;
	logic                ringing_q, ringing_d;
	logic                buzzer_q, buzzer_d;

	logic    advance;
	logic    is_tick;
	digits_t time_next;
	rsp_t    res_d;

	// the stage item moves on when the result register is free or being emptied
	assign advance   = req_valid_s1 && (!res_valid_q || res_ready);
	assign req_ready = !req_valid_s1 || advance;

	// tick decode kept apart from the state update, which reads the new time
	assign is_tick = (req_s1.req_type == REQ_TICK);

	acc_timekeeper u_timekeeper (
		.clk              (clk),
		.arst_n           (arst_n),
		.tick             (advance && is_tick),
		.ticks_per_second (tps_q),
		.time_next        (time_next)
	);

	// request decode and alarm state update
	always_comb begin
		alarm_d   = alarm_q;
		cursor_d  = cursor_q;
		mode_d    = mode_q;
		confirm_d = confirm_q;
		armed_d   = armed_q;
		ringing_d = ringing_q;
		buzzer_d  = buzzer_q;

		unique case (req_s1.req_type)
			REQ_TICK: begin
				// buzzer follows the ringing state from before this tick
				if (ringing_q) begin
					buzzer_d = ~buzzer_q;
				end
			end
			REQ_SET_MODE: begin
				mode_d = 1'b1;
			end
			REQ_DIGIT: begin
				if (mode_q && req_s1.key_digit <= LAST_DIGIT && cursor_q < CURSOR_FULL) begin
					alarm_d[cursor_q] = req_s1.key_digit;
					cursor_d          = cursor_q + CURSOR_W'(1);
				end
			end
			REQ_BACKSPACE: begin
				// works in any mode, nothing to do on an empty entry
				if (cursor_q != '0) begin
					cursor_d          = cursor_q - CURSOR_W'(1);
					alarm_d[cursor_d] = BLANK_DIGIT;
				end
			end
			REQ_CONFIRM: begin
				confirm_d = 1'b1;
			end
			REQ_CANCEL: begin
				// cursor and armed flag stay as they are
				if (ringing_q) begin
					ringing_d = 1'b0;
					mode_d    = 1'b0;
					buzzer_d  = 1'b0;
					alarm_d   = {DIGIT_COUNT{BLANK_DIGIT}};
				end
			end
			default: begin
				// unused request codes only report the state
			end
		endcase

		// full entry plus a pending confirm arms the alarm
		if (cursor_d == CURSOR_FULL && confirm_d) begin
			cursor_d  = '0;
			confirm_d = 1'b0;
			armed_d   = 1'b1;
		end

		// compare against the time after this request
		if (armed_d && time_next == alarm_d) begin
			ringing_d = 1'b1;
		end
	end

	// result fields
	always_comb begin
		res_d.hour_tens     = time_next[POS_HOUR_TENS][1:0];
		res_d.hour_ones     = time_next[POS_HOUR_ONES];
		res_d.minute_tens   = time_next[POS_MINUTE_TENS][2:0];
		res_d.minute_ones   = time_next[POS_MINUTE_ONES];
		res_d.second_tens   = time_next[POS_SECOND_TENS][2:0];
		res_d.second_ones   = time_next[POS_SECOND_ONES];
		res_d.alarm_armed   = armed_d;
		res_d.alarm_ringing = ringing_d;
		res_d.buzzer_level  = buzzer_d;
		res_d.entry_cursor  = cursor_d;
		res_d.setting_mode  = mode_d;
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
		end else if (cfg_we) begin
			tps_q <= cfg_data;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req_ready) begin
			req_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	// alarm and entry state, committed when the request is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_q   <= {DIGIT_COUNT{BLANK_DIGIT}};
			cursor_q  <= '0;
			mode_q    <= 1'b0;
			confirm_q <= 1'b0;
			armed_q   <= 1'b0;
			ringing_q <= 1'b0;
			buzzer_q  <= 1'b0;
		end else if (advance) begin
			alarm_q   <= alarm_d;
			cursor_q  <= cursor_d;
			mode_q    <= mode_d;
			confirm_q <= confirm_d;
			armed_q   <= armed_d;
			ringing_q <= ringing_d;
			buzzer_q  <= buzzer_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire
